>>> rtl/afc_pkg.sv
`timescale 1ns / 1ps

package afc_pkg;

  // Field widths
  localparam int ANGLE_W = 18;
  localparam int OUT_W   = 19;
  localparam int THR_W   = 17;
  localparam int WIN_W   = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Fixed-point format and full turn
  localparam int ANGLE_FRAC_BITS = 8;
  localparam logic signed [OUT_W-1:0] FULL_TURN = OUT_W'(360 * (1 << ANGLE_FRAC_BITS));

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'd1;

  // Register reset values
  localparam logic [THR_W-1:0] THRESHOLD_RST = 17'd51200;
  localparam logic [WIN_W-1:0] WINDOW_RST    = 8'd100;

  // Flip kind codes
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUB  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd2;

  // Status of the serial multiply-compare unit
  typedef struct packed {
    logic busy;
    logic done;
    logic over;
    logic under;
  } cmp_stat_t;

endpackage

>>> rtl/afc_ring.sv
`timescale 1ns / 1ps

module afc_ring #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 19
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/afc_cmp.sv
`timescale 1ns / 1ps

module afc_cmp #(
  parameter int KW = 8,
  parameter int SW = 27
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [afc_pkg::ANGLE_W-1:0] x,
  input  logic        [afc_pkg::THR_W-1:0]   thr,
  input  logic        [KW-1:0]               k,
  input  logic signed [SW-1:0]               s,
  output afc_pkg::cmp_stat_t                 stat
);

  localparam int MW = SW + 2;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_CMP  = 2'd2;

  logic [1:0]           phase_r;
  logic [KW-1:0]        mk_r;
  logic signed [MW-1:0] mx_r;
  logic signed [MW-1:0] mt_r;
  logic signed [MW-1:0] acx_r;
  logic signed [MW-1:0] act_r;
  logic                 done_r;
  logic                 over_r;
  logic                 under_r;

  // Control: idle, shift-add over the bits of k, then compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        P_IDLE: begin
          if (start) begin
            phase_r <= P_MUL;
          end
        end
        P_MUL: begin
          if (mk_r == '0) begin
            phase_r <= P_CMP;
          end
        end
        P_CMP: begin
          done_r  <= 1'b1;
          phase_r <= P_IDLE;
        end
        default: begin
          phase_r <= P_IDLE;
        end
      endcase
    end
  end

  // Datapath: acx accumulates x*k - s, act accumulates thr*k
  always_ff @(posedge clk) begin
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          mx_r  <= {{(MW-afc_pkg::ANGLE_W){x[afc_pkg::ANGLE_W-1]}}, x};
          mt_r  <= {{(MW-afc_pkg::THR_W){1'b0}}, thr};
          mk_r  <= k;
          acx_r <= -{{(MW-SW){s[SW-1]}}, s};
          act_r <= '0;
        end
      end
      P_MUL: begin
        if (mk_r != '0) begin
          if (mk_r[0]) begin
            acx_r <= acx_r + mx_r;
            act_r <= act_r + mt_r;
          end
          mx_r <= mx_r <<< 1;
          mt_r <= mt_r <<< 1;
          mk_r <= mk_r >> 1;
        end
      end
      P_CMP: begin
        over_r  <= acx_r > act_r;
        under_r <= acx_r < -act_r;
      end
      default: begin
      end
    endcase
  end

  assign stat.busy  = (phase_r != P_IDLE);
  assign stat.done  = done_r;
  assign stat.over  = over_r;
  assign stat.under = under_r;

endmodule

>>> rtl/angle_flip_corrector.sv
// Flow: an accepted item launches the serial multiply-compare over the bits of k, k being
//   min(window length, stored outputs); the result is then written back and registered.
// The first item after a window length write also re-sums the window through the
//   ring's single read port, one entry a cycle, before the compare starts.
// Throughput: one item at a time; the serial multiply-compare sets the pace.
// Reset (rst_n, synchronous): history empty, sum zero, registers at their defaults.
`timescale 1ns / 1ps

module angle_flip_corrector #(
  parameter int MAX_WINDOW = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [afc_pkg::ANGLE_W-1:0]   in_angle_in,
  input  logic                                 in_series_start,
  // Result requests
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [afc_pkg::OUT_W-1:0]     out_angle_out,
  output logic        [afc_pkg::KIND_W-1:0]    out_flip_kind,
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [afc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [afc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW = $clog2(MAX_WINDOW + 1);
  localparam int EW = AW + 1;
  localparam int WW = (KW > afc_pkg::WIN_W) ? KW : afc_pkg::WIN_W;
  localparam int SW = afc_pkg::OUT_W + KW;
  localparam int OW = afc_pkg::OUT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  logic [1:0]                         state_r;
  logic [afc_pkg::THR_W-1:0]          thr_r;
  logic [afc_pkg::WIN_W-1:0]          win_r;
  logic                               dirty_r;
  logic signed [afc_pkg::ANGLE_W-1:0] x_r;
  logic [KW-1:0]                      fill_r;
  logic [AW-1:0]                      wp_r;
  logic signed [SW-1:0]               sum_r;
  logic [KW-1:0]                      k_r;
  logic [KW-1:0]                      left_r;
  logic [AW-1:0]                      rp_r;
  logic                               rd_vld_r;
  logic                               go_r;
  logic signed [OW-1:0]               res_r;
  logic [afc_pkg::KIND_W-1:0]         kind_r;
  logic                               out_valid_r;
  logic signed [OW-1:0]               out_angle_r;
  logic [afc_pkg::KIND_W-1:0]         out_kind_r;

  logic [WW-1:0]        win_ext;
  logic [KW-1:0]        w_eff;
  logic [KW-1:0]        fill_use;
  logic [KW-1:0]        k_nxt;
  logic [KW-1:0]        w_gap;
  logic [EW-1:0]        ev_sum;
  logic [AW-1:0]        ev_addr;
  logic [AW-1:0]        wp_prev;
  logic [AW-1:0]        rp_prev;
  logic [AW-1:0]        wp_next;
  logic                 in_acc;
  logic                 out_free;
  logic                 evict;
  logic                 resum;
  logic                 sum_done;
  logic                 ring_re;
  logic [AW-1:0]        ring_ra;
  logic [OW-1:0]        ring_rd;
  logic                 ring_we;
  logic signed [SW-1:0] rd_ext;
  logic signed [SW-1:0] res_ext;
  logic signed [OW-1:0] x_ext;
  afc_pkg::cmp_stat_t   cmp_stat;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid_r || out_ready;

  // Effective window: zero counts as one, saturate at the ring depth
  assign win_ext = WW'(win_r);
  always_comb begin
    if (win_r == '0) begin
      w_eff = KW'(1);
    end else if (win_ext > WW'(MAX_WINDOW)) begin
      w_eff = KW'(MAX_WINDOW);
    end else begin
      w_eff = KW'(win_ext);
    end
  end

  // Window size for the item being accepted
  assign fill_use = in_series_start ? '0 : fill_r;
  assign k_nxt    = (fill_use < w_eff) ? fill_use : w_eff;

  // Re-sum needed on accept, and end of the re-sum walk
  assign resum    = dirty_r && !in_series_start && (k_nxt != '0);
  assign sum_done = (state_r == ST_SUM) && !rd_vld_r && (left_r == '0);

  // Pointer arithmetic modulo the ring depth
  assign wp_prev = (wp_r == '0) ? AW'(MAX_WINDOW - 1) : wp_r - AW'(1);
  assign rp_prev = (rp_r == '0) ? AW'(MAX_WINDOW - 1) : rp_r - AW'(1);
  assign wp_next = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);

  // Oldest entry of the window, dropped once the window is full
  assign w_gap   = KW'(MAX_WINDOW) - w_eff;
  assign ev_sum  = EW'(wp_r) + EW'(w_gap);
  assign ev_addr = (ev_sum >= EW'(MAX_WINDOW)) ? AW'(ev_sum - EW'(MAX_WINDOW)) : AW'(ev_sum);
  assign evict   = (fill_r >= w_eff);

  // Ring read: window re-sum walk, else the eviction slot
  assign ring_re = ((state_r == ST_SUM) && (left_r != '0)) || (state_r == ST_MUL);
  assign ring_ra = (state_r == ST_SUM) ? rp_r : ev_addr;
  assign ring_we = (state_r == ST_WB) && out_free;

  assign rd_ext  = {{(SW-OW){ring_rd[OW-1]}}, ring_rd};
  assign res_ext = {{(SW-OW){res_r[OW-1]}}, res_r};
  assign x_ext   = {{(OW-afc_pkg::ANGLE_W){x_r[afc_pkg::ANGLE_W-1]}}, x_r};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= afc_pkg::THRESHOLD_RST;
      win_r <= afc_pkg::WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        afc_pkg::REG_THRESHOLD: thr_r <= cfg_data[afc_pkg::THR_W-1:0];
        afc_pkg::REG_WINDOW:    win_r <= cfg_data[afc_pkg::WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dirty_r     <= 1'b0;
      fill_r      <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      left_r      <= '0;
      rd_vld_r    <= 1'b0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Launch the compare once the window sum is ready
      go_r     <= (in_acc && !resum) || sum_done;
      rd_vld_r <= (state_r == ST_SUM) && (left_r != '0);
      // Hold a result until the receiver takes it
      if (ring_we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Window length write invalidates the running sum
      if (cfg_valid && cfg_ready && (cfg_index == afc_pkg::REG_WINDOW)) begin
        dirty_r <= 1'b1;
      end else if ((in_acc && in_series_start) || sum_done) begin
        dirty_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            k_r    <= k_nxt;
            fill_r <= fill_use;
            if (in_series_start) begin
              wp_r  <= '0;
              sum_r <= '0;
            end
            if (resum) begin
              // Re-sum the window from the newest entry back
              sum_r   <= '0;
              left_r  <= k_nxt;
              rp_r    <= wp_prev;
              state_r <= ST_SUM;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_SUM: begin
          if (left_r != '0) begin
            left_r <= left_r - KW'(1);
            rp_r   <= rp_prev;
          end
          if (rd_vld_r) begin
            sum_r <= sum_r + rd_ext;
          end else if (left_r == '0) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cmp_stat.done) begin
            if (cmp_stat.over) begin
              res_r  <= x_ext - afc_pkg::FULL_TURN;
              kind_r <= afc_pkg::KIND_SUB;
            end else if (cmp_stat.under) begin
              res_r  <= x_ext + afc_pkg::FULL_TURN;
              kind_r <= afc_pkg::KIND_ADD;
            end else begin
              res_r  <= x_ext;
              kind_r <= afc_pkg::KIND_NONE;
            end
            state_r <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_free) begin
            // Push the result and slide the window sum
            wp_r <= wp_next;
            if (fill_r != KW'(MAX_WINDOW)) begin
              fill_r <= fill_r + KW'(1);
            end
            sum_r   <= evict ? sum_r + res_ext - rd_ext : sum_r + res_ext;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Input sample and output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_angle_in;
    end
    if (ring_we) begin
      out_angle_r <= res_r;
      out_kind_r  <= kind_r;
    end
  end

  afc_ring #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW),
    .DW    (OW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (wp_r),
    .wr_data (res_r),
    .rd_en   (ring_re),
    .rd_addr (ring_ra),
    .rd_data (ring_rd)
  );

  afc_cmp #(
    .KW (KW),
    .SW (SW)
  ) u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .x     (x_r),
    .thr   (thr_r),
    .k     (k_r),
    .s     (sum_r),
    .stat  (cmp_stat)
  );

  assign out_valid     = out_valid_r;
  assign out_angle_out = out_angle_r;
  assign out_flip_kind = out_kind_r;

  // A series start empties the history
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_series_start) |=> (fill_r == '0) && (sum_r == '0))
    else $error("series start did not clear history");

  // Fill count never passes the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= KW'(MAX_WINDOW))
    else $error("fill count beyond ring depth");

  // Compare unit is quiet while the window is re-summed
  a_cmp_idle_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> !cmp_stat.busy)
    else $error("compare unit busy during window sum");

  // Compare results arrive only while waiting for them
  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_stat.done |-> (state_r == ST_MUL))
    else $error("compare done outside multiply state");

endmodule
